>>> src/movs_pkg.sv
package movs_pkg;

   localparam int MAX_SAMPLES = 7;
   localparam int DIST_W      = 16;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef struct packed {
      logic accept;
      logic sel_step;
      logic load_out;
   } movs_cmd_type;

   typedef struct packed {
      logic hit;
   } movs_stat_type;

endpackage

>>> src/movs_datapath.sv
module movs_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  movs_pkg::movs_cmd_type   cmd,
   output movs_pkg::movs_stat_type  stat,
   input  movs_pkg::dist_type       req_distance,
   input  logic                     req_is_valid,
   input  logic                     req_last,
   output movs_pkg::dist_type       rsp_median,
   output logic                     rsp_found
);
   import movs_pkg::*;

   localparam cnt_type MAX_CNT = CNT_W'(MAX_SAMPLES);

   dist_type store_ff [MAX_SAMPLES];
   cnt_type  valid_count_ff, valid_count_in;
   cnt_type  items_seen_ff, items_seen_in;
   cnt_type  n_ff, n_in;
   idx_type  idx_ff, idx_in;
   dist_type median_ff;
   logic     found_ff;

   logic     store_we;
   cnt_type  cnt_next;
   dist_type cand;
   cnt_type  less_cnt;
   cnt_type  leq_cnt;
   cnt_type  half;
   logic     hit;

   // rank of the candidate among the stored words
   always_comb begin
      cand     = store_ff[idx_ff];
      less_cnt = '0;
      leq_cnt  = '0;
      for (int j = 0; j < MAX_SAMPLES; j++) begin
         if (CNT_W'(j) < n_ff) begin
            if (store_ff[j] < cand) begin
               less_cnt = less_cnt + CNT_W'(1);
            end
            if (store_ff[j] <= cand) begin
               leq_cnt = leq_cnt + CNT_W'(1);
            end
         end
      end
      half = n_ff >> 1;
      hit  = (n_ff == '0) || ((less_cnt <= half) && (half < leq_cnt));
   end

   assign stat.hit = hit;

   always_comb begin
      store_we       = 1'b0;
      cnt_next       = valid_count_ff;
      valid_count_in = valid_count_ff;
      items_seen_in  = items_seen_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      if (cmd.accept) begin
         if (items_seen_ff < MAX_CNT) begin
            if (req_is_valid && (valid_count_ff < MAX_CNT)) begin
               store_we = 1'b1;
               cnt_next = valid_count_ff + CNT_W'(1);
            end
            items_seen_in = items_seen_ff + CNT_W'(1);
         end
         valid_count_in = cnt_next;
         if (req_last) begin
            n_in           = cnt_next;
            valid_count_in = '0;
            items_seen_in  = '0;
            idx_in         = '0;
         end
      end
      if (cmd.sel_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_count_ff <= '0;
         items_seen_ff  <= '0;
         n_ff           <= '0;
         idx_ff         <= '0;
      end else begin
         valid_count_ff <= valid_count_in;
         items_seen_ff  <= items_seen_in;
         n_ff           <= n_in;
         idx_ff         <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[valid_count_ff[IDX_W-1:0]] <= req_distance;
      end
      if (cmd.load_out) begin
         median_ff <= (n_ff != '0) ? cand : '0;
         found_ff  <= (n_ff != '0);
      end
   end

   assign rsp_median = median_ff;
   assign rsp_found  = found_ff;

   a_count_le_seen : assert property (@(posedge clock) disable iff (reset)
      valid_count_ff <= items_seen_ff)
      else $error("more stored words than words seen");

   a_seen_bound : assert property (@(posedge clock) disable iff (reset)
      items_seen_ff <= MAX_CNT)
      else $error("run counter beyond limit");

   a_step_in_range : assert property (@(posedge clock) disable iff (reset)
      cmd.sel_step |-> (n_ff != '0) && (CNT_W'(idx_ff) + CNT_W'(1) < n_ff))
      else $error("candidate search ran past stored words");

   a_load_on_hit : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> hit && !cmd.sel_step)
      else $error("result loaded without a selected candidate");

endmodule

>>> src/movs_control.sv
module movs_control (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output movs_pkg::movs_cmd_type   cmd,
   input  movs_pkg::movs_stat_type  stat
);
   import movs_pkg::*;

   typedef enum logic {
      IDLE,
      SELECT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = SELECT;
            end
         end
         SELECT: begin
            if (!stat.hit) begin
               cmd.sel_step = 1'b1;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_accept_in_select : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SELECT) |-> !cmd.accept)
      else $error("word taken during selection");

   a_load_returns_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (state_ff == IDLE) && rsp_valid_ff)
      else $error("result load did not present a word");

   a_last_starts_select : assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_last) |=> (state_ff == SELECT))
      else $error("last word did not start selection");

endmodule

>>> src/median_of_valid_samples.sv
// median_of_valid_samples
// Input channel (req_): one distance word per handshake with a validity flag
// and a last marker. Only the first seven words of a run count; invalid ones
// are skipped but use up a place. Valid ones are stored.
// Result channel (rsp_): one word per run, sent after the word marked last:
// the upper median of the stored samples (rank count/2 in ascending order),
// or found = 0 and median = 0 when the run held no valid sample.
// Timing: words that are not last are taken back to back.
// After a last word the block tests one stored sample per cycle against all
// the others (compare-and-count unit) until it meets the median, then loads
// the result; n, the number of valid samples, is at most 7.
// req_ready is low during that search and until the result is loaded.
// The result sits in an output register; while the receiver stalls, the next
// run is taken in, and only the end of that next run waits for the register.
// Reset (synchronous, active high) empties the run and drops rsp_valid.
module median_of_valid_samples (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  movs_pkg::dist_type  req_distance,
   input  logic                req_is_valid,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output movs_pkg::dist_type  rsp_median,
   output logic                rsp_found
);
   import movs_pkg::*;

   movs_cmd_type  cmd;
   movs_stat_type stat;

   movs_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   movs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_distance (req_distance),
      .req_is_valid (req_is_valid),
      .req_last     (req_last),
      .rsp_median   (rsp_median),
      .rsp_found    (rsp_found)
   );

endmodule

>>> tb/sv/median_of_valid_samples_test.sv
module median_of_valid_samples_test;
   timeunit 1ns;
   timeprecision 1ps;

   import movs_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      dist_type median;
      logic     found;
   } median_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   dist_type req_distance = '0;
   logic     req_is_valid = 1'b0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   dist_type rsp_median;
   logic     rsp_found;

   median_result_type pending_medians[$];
   dist_type          held_samples[MAX_SAMPLES];
   int                held_valid = 0;
   int                held_seen = 0;
   int                mismatch_count = 0;
   int                words_sent = 0;
   int                idle_cycles = 0;
   bit                tx_random = 1'b1;
   bit                rx_random = 1'b1;
   int                rx_hold = 0;
   int                rx_stall = 0;

   median_of_valid_samples dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_distance (req_distance),
      .req_is_valid (req_is_valid),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_median   (rsp_median),
      .rsp_found    (rsp_found)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic dist_type pick_distance();
      int roll;
      roll = $urandom_range(0, 7);
      case (roll)
         0: return '0;
         1: return '1;
         2: return dist_type'($urandom_range(100, 107));
         default: return dist_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // upper median of the samples held for the current run
   function automatic dist_type upper_median();
      dist_type work[MAX_SAMPLES];
      dist_type key;
      int       i;
      int       j;
      for (i = 0; i < MAX_SAMPLES; i++) work[i] = held_samples[i];
      for (i = 1; i < held_valid; i++) begin
         key = work[i];
         j = i;
         while (j > 0 && work[j-1] > key) begin
            work[j] = work[j-1];
            j--;
         end
         work[j] = key;
      end
      return work[held_valid / 2];
   endfunction

   task automatic track_word(input dist_type sample, input logic ok, input logic ends);
      median_result_type res;
      if (held_seen < MAX_SAMPLES) begin
         if (ok && held_valid < MAX_SAMPLES) begin
            held_samples[held_valid] = sample;
            held_valid++;
         end
         held_seen++;
      end
      if (ends) begin
         if (held_valid == 0) begin
            res.median = '0;
            res.found  = 1'b0;
         end else begin
            res.median = upper_median();
            res.found  = 1'b1;
         end
         pending_medians.push_back(res);
         held_valid = 0;
         held_seen  = 0;
      end
   endtask

   task automatic send_word(input dist_type sample, input logic ok, input logic ends);
      int gap;
      gap = tx_random ? pick_gap() : 0;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_distance <= sample;
      req_is_valid <= ok;
      req_last     <= ends;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_word(sample, ok, ends);
      words_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_run(input int len, input int valid_pct);
      int i;
      for (i = 0; i < len; i++)
         send_word(pick_distance(), $urandom_range(0, 99) < valid_pct, i == len - 1);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      stop_sending();
      while (pending_medians.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      // single samples at both extremes, single invalid
      send_word(16'h0000, 1'b1, 1'b1);
      send_word(16'hFFFF, 1'b1, 1'b1);
      send_word(16'h1234, 1'b0, 1'b1);
      // even count gives the upper median
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'h0000, 1'b1, 1'b0);
      send_word(16'h8000, 1'b1, 1'b0);
      send_word(16'h7FFF, 1'b1, 1'b1);
      // words past the limit are ignored, last still closes the run
      send_word(16'h0010, 1'b1, 1'b0);
      send_word(16'hFFF0, 1'b1, 1'b0);
      send_word(16'h0030, 1'b1, 1'b0);
      send_word(16'h0030, 1'b1, 1'b0);
      send_word(16'hAAAA, 1'b1, 1'b0);
      send_word(16'h5555, 1'b1, 1'b0);
      send_word(16'h0001, 1'b1, 1'b0);
      send_word(16'h0000, 1'b1, 1'b0);
      send_word(16'h0000, 1'b1, 1'b1);
      // invalid words use up places
      send_word(16'hFFFF, 1'b0, 1'b0);
      send_word(16'h0000, 1'b0, 1'b0);
      send_word(16'h4000, 1'b0, 1'b0);
      send_word(16'h0200, 1'b1, 1'b0);
      send_word(16'h0100, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b0, 1'b0);
      send_word(16'h0000, 1'b0, 1'b0);
      send_word(16'h0001, 1'b1, 1'b1);
      // a single invalid word as a run of its own
      send_word(16'h0050, 1'b0, 1'b1);
   endtask

   task automatic test_random_runs(input int word_goal);
      int start;
      int runs;
      start = words_sent;
      runs = 0;
      while (words_sent - start < word_goal) begin
         if (runs % 40 == 0) begin
            tx_random = (runs / 40) % 4 != 1;
            rx_random = (runs / 40) % 4 != 2;
         end
         if ($urandom_range(0, 9) < 8)
            send_run($urandom_range(1, MAX_SAMPLES), $urandom_range(50, 100));
         else
            send_run($urandom_range(MAX_SAMPLES + 1, 12), $urandom_range(30, 100));
         runs++;
      end
      tx_random = 1'b1;
      rx_random = 1'b1;
   endtask

   task automatic test_backpressure();
      int i;
      tx_random = 1'b0;
      stop_sending();
      rx_hold = HOLD_CYCLES;
      for (i = 0; i < 6; i++) send_run($urandom_range(1, MAX_SAMPLES), 90);
      tx_random = 1'b1;
   endtask

   task automatic test_drain_pause();
      int i;
      for (i = 0; i < 4; i++) send_run($urandom_range(1, 9), 80);
      wait_for_results();
      for (i = 0; i < 4; i++) send_run($urandom_range(1, 9), 80);
   endtask

   task automatic test_noise(input int word_goal);
      int start;
      start = words_sent;
      while (words_sent - start < word_goal) begin
         case ($urandom_range(0, 3))
            0: send_word(pick_distance(), 1'($urandom_range(0, 1)), 1'b1);
            1: send_run($urandom_range(1, 15), 0);
            2: send_run($urandom_range(1, 15), 50);
            default: send_run($urandom_range(8, 15), 100);
         endcase
      end
   endtask

   // receiver side ready with random stalls, steady ready in some phases, and an occasional long hold
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_ready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else if (!rx_random) begin
         rsp_ready <= 1'b1;
      end else if (rx_stall > 0) begin
         rsp_ready <= 1'b0;
         rx_stall = rx_stall - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rx_stall = pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      median_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected result word median %h found %b",
                     $time, rsp_median, rsp_found);
            mismatch_count++;
         end else begin
            exp_res = pending_medians.pop_front();
            if (rsp_median !== exp_res.median) begin
               $display("%0t: median mismatch expected %h actual %h",
                        $time, exp_res.median, rsp_median);
               mismatch_count++;
            end
            if (rsp_found !== exp_res.found) begin
               $display("%0t: found mismatch expected %b actual %b",
                        $time, exp_res.found, rsp_found);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_drain_pause();
      test_random_runs(1400);
      test_noise(250);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_medians.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
